// ----- src/skts_pkg.sv -----
// Package for the sorted key table search unit.
// Holds the field widths, command and state codes, and the control structs.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package skts_pkg;

  localparam int KEY_W           = 64;
  localparam int CMD_W           = 2;
  localparam int POS_W           = 10;
  localparam int TOTAL_W         = 11;
  localparam int OUT_DATA_W      = 40;
  localparam int DEF_MAX_ENTRIES = 1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_COMPARE,
    S_FINAL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_mid;
    logic step;
    logic rd_lo;
    logic finish;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic lo_lt_hi;
    logic bounds_ok;
  } dp_status_t;

endpackage

// ----- src/skts_datapath.sv -----
// Datapath of the sorted key table search unit: key memory, search bounds,
// group tracking and the result register. Driven by skts_controller.
// Depends on skts_pkg.
`timescale 1ns / 1ps

module skts_datapath import skts_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         status,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [KEY_W-1:0]   in_key,
  input  logic               in_eog,
  output logic               res_status,
  output logic               res_hit,
  output logic [POS_W-1:0]   res_position,
  output logic               res_group_done,
  output logic               res_group_hit,
  output logic [POS_W-1:0]   res_group_position,
  output logic [TOTAL_W-1:0] res_entry_total
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ENTRIES);

  logic [KEY_W-1:0] key_store [MAX_ENTRIES];
  logic [KEY_W-1:0] rdata_r;
  logic [KEY_W-1:0] key_r;
  logic             eog_r;
  logic [CW-1:0]    lo_r, lo_nxt;
  logic [CW-1:0]    hi_r, hi_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             group_seen_r, group_seen_nxt;
  logic [POS_W-1:0] group_pos_r, group_pos_nxt;

  logic             st_status_r, st_hit_r, st_gdone_r, st_ghit_r;
  logic [POS_W-1:0] st_pos_r, st_gpos_r;

  logic [CW-1:0]    mid;
  logic [AW-1:0]    rd_addr;
  logic             full;
  logic             mem_we;
  logic             hit_w;
  logic [31:0]      lo_ext;
  logic [31:0]      count_ext;
  logic [POS_W-1:0] lo_pos;
  logic             seen_w;
  logic [POS_W-1:0] last_w;

  assign mid       = lo_r + CW'((hi_r - lo_r) >> 1);
  assign rd_addr   = cmd.rd_mid ? mid[AW-1:0] : lo_r[AW-1:0];
  assign full      = (count_r >= MAX_COUNT);
  assign mem_we    = cmd.accept && (in_cmd == CMD_APPEND) && !full;
  assign lo_ext    = 32'(lo_r);
  assign count_ext = 32'(count_r);
  assign lo_pos    = lo_ext[POS_W-1:0];
  assign hit_w     = (lo_r < count_r) && (rdata_r == key_r);
  assign seen_w    = hit_w | group_seen_r;
  assign last_w    = hit_w ? lo_pos : group_pos_r;

  assign status.lo_lt_hi  = (lo_r < hi_r);
  assign status.bounds_ok = (count_r <= MAX_COUNT) && (lo_r <= hi_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_store[count_r[AW-1:0]] <= in_key;
    end
    if (cmd.rd_mid || cmd.rd_lo) begin
      rdata_r <= key_store[rd_addr];
    end
  end

  always_comb begin
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    group_seen_nxt = group_seen_r;
    group_pos_nxt  = group_pos_r;
    if (cmd.accept) begin
      unique case (in_cmd)
        CMD_CLEAR: begin
          count_nxt = '0;
        end
        CMD_APPEND: begin
          if (!full) begin
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_QUERY: begin
          lo_nxt = '0;
          hi_nxt = count_r;
        end
        default: begin
        end
      endcase
    end
    if (cmd.step) begin
      if (rdata_r < key_r) begin
        lo_nxt = mid + CW'(1);
      end else begin
        hi_nxt = mid;
      end
    end
    if (cmd.finish) begin
      if (eog_r) begin
        group_seen_nxt = 1'b0;
        group_pos_nxt  = '0;
      end else begin
        group_seen_nxt = seen_w;
        group_pos_nxt  = last_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      lo_r         <= '0;
      hi_r         <= '0;
      group_seen_r <= 1'b0;
      group_pos_r  <= '0;
    end else begin
      count_r      <= count_nxt;
      lo_r         <= lo_nxt;
      hi_r         <= hi_nxt;
      group_seen_r <= group_seen_nxt;
      group_pos_r  <= group_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r       <= in_key;
      eog_r       <= in_eog;
      st_status_r <= (in_cmd == CMD_APPEND) && full;
      st_hit_r    <= 1'b0;
      st_pos_r    <= '0;
      st_gdone_r  <= 1'b0;
      st_ghit_r   <= 1'b0;
      st_gpos_r   <= '0;
    end
    if (cmd.finish) begin
      st_hit_r   <= hit_w;
      st_pos_r   <= hit_w ? lo_pos : '0;
      st_gdone_r <= eog_r;
      st_ghit_r  <= eog_r && seen_w;
      st_gpos_r  <= (eog_r && seen_w) ? last_w : '0;
    end
    if (cmd.load_out) begin
      res_status         <= st_status_r;
      res_hit            <= st_hit_r;
      res_position       <= st_pos_r;
      res_group_done     <= st_gdone_r;
      res_group_hit      <= st_ghit_r;
      res_group_position <= st_gpos_r;
      res_entry_total    <= count_ext[TOTAL_W-1:0];
    end
  end

endmodule

// ----- src/skts_controller.sv -----
// Controller of the sorted key table search unit: sequences the binary
// search steps and owns the output valid flag. Depends on skts_pkg.
`timescale 1ns / 1ps

module skts_controller import skts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  dp_status_t       status,
  output ctrl_cmd_t        cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_cmd == CMD_QUERY) ? S_SEARCH : S_DONE;
        end
      end
      S_SEARCH: begin
        state_nxt = status.lo_lt_hi ? S_COMPARE : S_FINAL;
      end
      S_COMPARE: begin
        state_nxt = S_SEARCH;
      end
      S_FINAL: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_tvalid;
      end
      S_SEARCH: begin
        cmd.rd_mid = status.lo_lt_hi;
        cmd.rd_lo  = !status.lo_lt_hi;
      end
      S_COMPARE: begin
        cmd.step = 1'b1;
      end
      S_FINAL: begin
        cmd.finish = 1'b1;
      end
      S_DONE: begin
        cmd.load_out = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- src/sorted_key_table_search_unit.sv -----
// Top level of the sorted key table search unit.
// Instantiates skts_controller and skts_datapath; depends on skts_pkg.
//
// The input stream carries one command word per transfer: in_tuser is the
// command (clear, append, query), in_tdata the 64-bit key and in_tlast the
// end-of-group mark of a query. Every input word yields exactly one result
// word on the output stream; out_tlast marks a result that closes a group.
// Clear and append take effect when the word is accepted and produce a
// result without a search. A query runs a lower-bound binary search over
// the keys held so far; each search step is one read of the key memory and
// one compare in separate states, since the memory read data is registered.
// One word is worked on at a time: the next word is accepted in the cycle
// after a result is loaded. The result sits in an output register, so the
// next word is accepted while a result still waits; if the receiver stalls,
// the following result waits in its final state until the register is free.
// Reset empties the table and clears the group state; the key memory itself
// is not cleared.
`timescale 1ns / 1ps

module sorted_key_table_search_unit import skts_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0: key[63:0].
  input  logic [KEY_W-1:0]      in_tdata,
  // Fields from bit 0: cmd[1:0].
  input  logic [CMD_W-1:0]      in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Fields from bit 0: status, hit, position[9:0], group_hit,
  // group_position[9:0], entry_total[10:0], zero padding.
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  ctrl_cmd_t          dp_cmd;
  dp_status_t         dp_status;
  logic               res_status;
  logic               res_hit;
  logic [POS_W-1:0]   res_position;
  logic               res_group_done;
  logic               res_group_hit;
  logic [POS_W-1:0]   res_group_position;
  logic [TOTAL_W-1:0] res_entry_total;

  skts_controller u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_cmd     (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (dp_status),
    .cmd        (dp_cmd)
  );

  skts_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (dp_cmd),
    .status             (dp_status),
    .in_cmd             (in_tuser),
    .in_key             (in_tdata),
    .in_eog             (in_tlast),
    .res_status         (res_status),
    .res_hit            (res_hit),
    .res_position       (res_position),
    .res_group_done     (res_group_done),
    .res_group_hit      (res_group_hit),
    .res_group_position (res_group_position),
    .res_entry_total    (res_entry_total)
  );

  assign out_tdata = {6'd0, res_entry_total, res_group_position, res_group_hit,
                      res_position, res_hit, res_status};
  assign out_tlast = res_group_done;

  a_bounds_ok: assert property (@(posedge clk) disable iff (!rst_n)
    dp_status.bounds_ok)
    else $error("search bounds or entry count out of range");

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a word is still in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.load_out |-> (!out_tvalid || out_tready))
    else $error("result register loaded while holding an untaken word");

endmodule
